>>> hdl/sparse_table_range_min_index_assert.svh
// Assertion macros for the range-minimum engine RTL.
`ifndef SPARSE_TABLE_RANGE_MIN_INDEX_ASSERT_SVH
`define SPARSE_TABLE_RANGE_MIN_INDEX_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define STRMI_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define STRMI_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/strmi_pkg.sv
// Types, codes and helper functions for the range-minimum engine.
package strmi_pkg;

  // Fixed field widths of the channels
  localparam int MODE_W   = 2;
  localparam int VALUE_W  = 16;
  localparam int POS_W    = 10;
  localparam int LEN_W    = 11;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 11;
  localparam int LOG_W    = 4;

  // Transaction modes
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BUILD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD  = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_BL0,
    ST_BTRD,
    ST_BVRD,
    ST_BCMP,
    ST_QCHK,
    ST_QTRD,
    ST_QVRD,
    ST_QCMP,
    ST_OUT
  } strmi_state_t;

  // Position of the highest set bit of a range length
  function automatic logic [LOG_W-1:0] floor_log2(input logic [LEN_W-1:0] len);
    logic [LOG_W-1:0] lvl;
    lvl = '0;
    for (int b = 1; b < LEN_W; b++) begin
      if (len[b]) lvl = LOG_W'(b);
    end
    return lvl;
  endfunction

endpackage

>>> hdl/strmi_pick.sv
// Shared compare unit: picks the smaller of two indexed values, ties to the second.
module strmi_pick #(
  parameter int IW = 10,
  parameter int VW = 16
) (
  input  logic [IW-1:0] idx_a,
  input  logic [IW-1:0] idx_b,
  input  logic [VW-1:0] val_a,
  input  logic [VW-1:0] val_b,
  output logic [IW-1:0] sel_idx,
  output logic [VW-1:0] sel_val
);

  logic a_less;

  // Take the first side only when strictly smaller
  assign a_less  = (val_a < val_b);
  assign sel_idx = a_less ? idx_a : idx_b;
  assign sel_val = a_less ? val_a : val_b;

endmodule

>>> hdl/sparse_table_range_min_index.sv
// Range-minimum engine: value store, sparse index table and query sequencer.
//
// One input channel (in_valid/in_ready) carries load, build and query
// transactions; one result channel (out_valid/out_ready) returns exactly one
// result per transaction, in order. The block works on one transaction at a
// time: in_ready is high only while the sequencer is idle.
// Steps from the accepting edge to out_valid: a load goes through the load
// state, then the output register; a query runs range check, table reads,
// value reads, compare, output register; a rejected query goes from the range
// check to the output register, and an unused mode or an empty-store build goes
// straight to it. A build of N elements writes level 0 one entry a cycle; each
// of the N - 2^j + 1 entries of a higher level j then passes through the shared
// compare unit (table read, value read, compare and write).
// The result sits in an output register, so the next transaction is accepted
// while a result waits; a stalled receiver holds the sequencer only once the
// next result is ready to be delivered.
// Reset clears the element count, the built mark and the output valid; the
// value store and table hold unknown data until written, and no read ever
// reaches an unwritten entry.
module sparse_table_range_min_index #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int VALUE_WIDTH  = 16,
  parameter int LEVELS       = 11
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [strmi_pkg::MODE_W-1:0]    in_mode,
  input  logic [strmi_pkg::VALUE_W-1:0]   in_value,
  input  logic [strmi_pkg::POS_W-1:0]     in_left,
  input  logic [strmi_pkg::POS_W-1:0]     in_right,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [strmi_pkg::POS_W-1:0]     out_min_index,
  output logic [strmi_pkg::VALUE_W-1:0]   out_min_value,
  output logic [strmi_pkg::STATUS_W-1:0]  out_status,
  output logic [strmi_pkg::TOTAL_W-1:0]   out_element_total
);

  import strmi_pkg::*;

  localparam int IW     = $clog2(MAX_ELEMENTS);
  localparam int CW     = $clog2(MAX_ELEMENTS + 1);
  localparam int TDEPTH = LEVELS * MAX_ELEMENTS;
  localparam int TW     = $clog2(TDEPTH);
  localparam int LW     = $clog2(LEVELS);
  localparam int NW0    = (CW > LEVELS) ? CW : LEVELS;
  localparam int NW     = ((NW0 > LEN_W) ? NW0 : LEN_W) + 2;

  strmi_state_t state_r, state_nxt;

  // Request and sequencer registers
  logic [VALUE_WIDTH-1:0] value_r;
  logic [POS_W-1:0]       left_r, right_r;
  logic [CW-1:0]          count_r;
  logic                   table_ready_r;
  logic [NW-1:0]          bi_r, half_r;
  logic [LW-1:0]          lvl_r, q_lvl_r;
  logic [TW-1:0]          base_r, pbase_r;
  logic [POS_W-1:0]       q_start2_r;

  // Result and output registers
  logic [IW-1:0]          res_idx_r;
  logic [VALUE_WIDTH-1:0] res_val_r;
  logic [STATUS_W-1:0]    res_status_r;
  logic                   out_valid_r;
  logic [POS_W-1:0]       out_min_index_r;
  logic [VALUE_W-1:0]     out_min_value_r;
  logic [STATUS_W-1:0]    out_status_r;
  logic [TOTAL_W-1:0]     out_total_r;

  // Memories and their registered read data
  logic [VALUE_WIDTH-1:0] value_mem [MAX_ELEMENTS];
  logic [IW-1:0]          tbl_mem   [TDEPTH];
  logic [IW-1:0]          tbl_a_q, tbl_b_q;
  logic [VALUE_WIDTH-1:0] val_a_q, val_b_q;

  // Memory controls
  logic                   vs_we, vs_re, tb_we, tb_re;
  logic [IW-1:0]          vs_waddr;
  logic [TW-1:0]          tb_waddr, tb_raddr_a, tb_raddr_b;
  logic [IW-1:0]          tb_wdata;

  // Derived conditions
  logic                   in_fire, out_load, load_ok;
  logic                   bl0_last, b_row_more, b_lvl_more, build_done;
  logic [LEN_W-1:0]       q_len;
  logic [LOG_W-1:0]       q_lvl_full;
  logic [POS_W-1:0]       q_start2;
  logic                   q_bad;
  logic [TW-1:0]          q_base;
  logic [IW-1:0]          pick_idx;
  logic [VALUE_WIDTH-1:0] pick_val;

  assign in_fire  = in_valid && in_ready;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);
  assign load_ok  = (NW'(count_r) < NW'(MAX_ELEMENTS));

  // Build loop bounds
  assign bl0_last   = ((bi_r + 1'b1) >= NW'(count_r));
  assign b_row_more = ((bi_r + 1'b1 + (half_r << 1)) <= NW'(count_r));
  assign b_lvl_more = ((32'(lvl_r) + 1) < LEVELS) && ((half_r << 2) <= NW'(count_r));
  assign build_done = ((state_r == ST_BL0) && bl0_last && (NW'(count_r) < NW'(2)))
                   || ((state_r == ST_BCMP) && !b_row_more && !b_lvl_more);

  // Query range check and level
  assign q_len      = LEN_W'(right_r) - LEN_W'(left_r) + LEN_W'(1);
  assign q_lvl_full = floor_log2(q_len);
  assign q_start2   = POS_W'(LEN_W'(right_r) + LEN_W'(1) - (LEN_W'(1) << q_lvl_full));
  assign q_bad      = !table_ready_r || (left_r > right_r)
                   || (NW'(right_r) >= NW'(count_r)) || (32'(q_lvl_full) >= LEVELS);
  assign q_base     = TW'(TW'(q_lvl_r) * TW'(MAX_ELEMENTS));

  // Shared compare unit
  strmi_pick #(
    .IW (IW),
    .VW (VALUE_WIDTH)
  ) u_pick (
    .idx_a   (tbl_a_q),
    .idx_b   (tbl_b_q),
    .val_a   (val_a_q),
    .val_b   (val_b_q),
    .sel_idx (pick_idx),
    .sel_val (pick_val)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_mode)
            MODE_LOAD:  state_nxt = ST_LOAD;
            MODE_BUILD: state_nxt = (count_r == '0) ? ST_OUT : ST_BL0;
            MODE_QUERY: state_nxt = ST_QCHK;
            default:    state_nxt = ST_OUT;
          endcase
        end
      end
      ST_LOAD: state_nxt = ST_OUT;
      ST_BL0: begin
        if (bl0_last) state_nxt = (NW'(count_r) >= NW'(2)) ? ST_BTRD : ST_OUT;
      end
      ST_BTRD: state_nxt = ST_BVRD;
      ST_BVRD: state_nxt = ST_BCMP;
      ST_BCMP: state_nxt = (b_row_more || b_lvl_more) ? ST_BTRD : ST_OUT;
      ST_QCHK: state_nxt = q_bad ? ST_OUT : ST_QTRD;
      ST_QTRD: state_nxt = ST_QVRD;
      ST_QVRD: state_nxt = ST_QCMP;
      ST_QCMP: state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and memory controls
  always_comb begin
    in_ready   = 1'b0;
    vs_we      = 1'b0;
    vs_re      = 1'b0;
    tb_we      = 1'b0;
    tb_re      = 1'b0;
    vs_waddr   = IW'(count_r);
    tb_waddr   = TW'(bi_r);
    tb_wdata   = IW'(bi_r);
    tb_raddr_a = pbase_r + TW'(bi_r);
    tb_raddr_b = pbase_r + TW'(bi_r + half_r);
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_LOAD: vs_we = load_ok;
      ST_BL0:  tb_we = 1'b1;
      ST_BTRD: tb_re = 1'b1;
      ST_BVRD: vs_re = 1'b1;
      ST_BCMP: begin
        tb_we    = 1'b1;
        tb_waddr = base_r + TW'(bi_r);
        tb_wdata = pick_idx;
      end
      ST_QTRD: begin
        tb_re      = 1'b1;
        tb_raddr_a = q_base + TW'(left_r);
        tb_raddr_b = q_base + TW'(q_start2_r);
      end
      ST_QVRD: vs_re = 1'b1;
      default: ;
    endcase
  end

  // Control state: sequencer, element count, built mark, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      count_r       <= '0;
      table_ready_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_LOAD) && load_ok) begin
        count_r       <= count_r + 1'b1;
        table_ready_r <= 1'b0;
      end
      if (build_done) table_ready_r <= 1'b1;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath: capture request, advance build indices, collect result
  always_ff @(posedge clk) begin
    if (in_fire) begin
      value_r   <= VALUE_WIDTH'(in_value);
      left_r    <= in_left;
      right_r   <= in_right;
      bi_r      <= '0;
      res_idx_r <= '0;
      res_val_r <= '0;
      case (in_mode)
        MODE_LOAD:  res_status_r <= STAT_OK;
        MODE_BUILD: res_status_r <= (count_r == '0) ? STAT_BAD : STAT_OK;
        MODE_QUERY: res_status_r <= STAT_OK;
        default:    res_status_r <= STAT_BAD;
      endcase
    end
    case (state_r)
      ST_LOAD: begin
        if (!load_ok) res_status_r <= STAT_FULL;
      end
      ST_BL0: begin
        if (bl0_last) begin
          bi_r    <= '0;
          lvl_r   <= LW'(1);
          half_r  <= NW'(1);
          pbase_r <= '0;
          base_r  <= TW'(MAX_ELEMENTS);
        end else begin
          bi_r <= bi_r + 1'b1;
        end
      end
      ST_BCMP: begin
        if (b_row_more) begin
          bi_r <= bi_r + 1'b1;
        end else if (b_lvl_more) begin
          bi_r    <= '0;
          lvl_r   <= lvl_r + 1'b1;
          half_r  <= half_r << 1;
          pbase_r <= base_r;
          base_r  <= base_r + TW'(MAX_ELEMENTS);
        end
      end
      ST_QCHK: begin
        q_lvl_r    <= LW'(q_lvl_full);
        q_start2_r <= q_start2;
        if (q_bad) res_status_r <= STAT_BAD;
      end
      ST_QCMP: begin
        res_idx_r <= pick_idx;
        res_val_r <= pick_val;
      end
      default: ;
    endcase
    if (out_load) begin
      out_min_index_r <= POS_W'(res_idx_r);
      out_min_value_r <= VALUE_W'(res_val_r);
      out_status_r    <= res_status_r;
      out_total_r     <= TOTAL_W'(count_r);
    end
  end

  // Value store: one write, two registered reads
  always_ff @(posedge clk) begin
    if (vs_we) value_mem[vs_waddr] <= value_r;
    if (vs_re) begin
      val_a_q <= value_mem[tbl_a_q];
      val_b_q <= value_mem[tbl_b_q];
    end
  end

  // Index table: one write, two registered reads
  always_ff @(posedge clk) begin
    if (tb_we) tbl_mem[tb_waddr] <= tb_wdata;
    if (tb_re) begin
      tbl_a_q <= tbl_mem[tb_raddr_a];
      tbl_b_q <= tbl_mem[tb_raddr_b];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_min_index     = out_min_index_r;
  assign out_min_value     = out_min_value_r;
  assign out_status        = out_status_r;
  assign out_element_total = out_total_r;

`include "sparse_table_range_min_index_assert.svh"

  `STRMI_CHK_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second transaction accepted while busy")
  `STRMI_CHK_NOW(a_built_by_seq, $past(rst_n) && table_ready_r && !$past(table_ready_r), $past(state_r) == ST_BCMP || $past(state_r) == ST_BL0, "built mark set outside a build")
  `STRMI_CHK_NOW(a_count_by_load, $past(rst_n) && count_r != $past(count_r), $past(state_r) == ST_LOAD && count_r == $past(count_r) + 1'b1, "element count changed outside a load")
  `STRMI_CHK_NOW(a_count_bound, $past(rst_n), NW'(count_r) <= NW'(MAX_ELEMENTS), "element count beyond capacity")
  `STRMI_CHK_NOW(a_out_by_seq, $past(rst_n) && out_valid_r && !$past(out_valid_r), $past(state_r) == ST_OUT, "result raised outside the output state")

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the sparse-table range-minimum engine.
`timescale 1ns / 100ps

module testbench;
  import strmi_pkg::*;

  localparam int STORE_DEPTH = 1024;
  localparam int TBL_LEVELS  = 11;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 450;
  localparam int LONG_HOLD    = 400;

  typedef struct packed {
    logic [POS_W-1:0]    min_index;
    logic [VALUE_W-1:0]  min_value;
    logic [STATUS_W-1:0] status;
    logic [TOTAL_W-1:0]  element_total;
  } min_answer_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [MODE_W-1:0]   in_mode;
  logic [VALUE_W-1:0]  in_value;
  logic [POS_W-1:0]    in_left;
  logic [POS_W-1:0]    in_right;
  logic                out_valid;
  logic                out_ready;
  logic [POS_W-1:0]    out_min_index;
  logic [VALUE_W-1:0]  out_min_value;
  logic [STATUS_W-1:0] out_status;
  logic [TOTAL_W-1:0]  out_element_total;

  // Shadow copy of the engine state
  logic [VALUE_W-1:0] value_mem [STORE_DEPTH];
  logic [POS_W-1:0]   index_tbl [TBL_LEVELS][STORE_DEPTH];
  int                 stored_count = 0;
  bit                 table_built = 1'b0;

  min_answer_t min_answer_q[$];

  bit calm = 1'b0;
  bit long_hold_req = 1'b0;
  int fail_count = 0;
  int sent_count = 0;
  int load_count = 0;
  int full_loads = 0;
  int build_count = 0;
  int query_count = 0;
  int answered_count = 0;

  sparse_table_range_min_index DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_value          (in_value),
    .in_left           (in_left),
    .in_right          (in_right),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_min_index     (out_min_index),
    .out_min_value     (out_min_value),
    .out_status        (out_status),
    .out_element_total (out_element_total)
  );

  always #1 clk = ~clk;

  // End a hung run
  initial begin
    #10_000_000;
    $display("[sparse_table_range_min_index] ERROR");
    $finish;
  end

  // Pick the position holding the smaller value; equal values go to b
  function automatic logic [POS_W-1:0] smaller_of(input logic [POS_W-1:0] a,
                                                  input logic [POS_W-1:0] b);
    return (value_mem[a] < value_mem[b]) ? a : b;
  endfunction

  // Apply one transaction to the shadow state and return its answer
  function automatic min_answer_t compute_min_answer(input logic [MODE_W-1:0] mode,
                                                     input logic [VALUE_W-1:0] value,
                                                     input logic [POS_W-1:0] left,
                                                     input logic [POS_W-1:0] right);
    min_answer_t ans;
    int l;
    int r;
    int lvl;
    int span;
    int start2;
    int i;
    int j;
    logic [POS_W-1:0] idx;
    ans = '0;
    ans.status = STAT_OK;
    l = left;
    r = right;
    case (mode)
      MODE_LOAD: begin
        load_count++;
        if (stored_count >= STORE_DEPTH) begin
          ans.status = STAT_FULL;
          full_loads++;
        end else begin
          value_mem[stored_count] = value;
          stored_count++;
          table_built = 1'b0;
        end
      end
      MODE_BUILD: begin
        build_count++;
        if (stored_count == 0) begin
          ans.status = STAT_BAD;
        end else begin
          for (i = 0; i < stored_count; i++) index_tbl[0][i] = POS_W'(i);
          for (j = 1; j < TBL_LEVELS && (1 << j) <= stored_count; j++) begin
            span = 1 << j;
            for (i = 0; i + span <= stored_count; i++)
              index_tbl[j][i] = smaller_of(index_tbl[j-1][i], index_tbl[j-1][i + span/2]);
          end
          table_built = 1'b1;
        end
      end
      MODE_QUERY: begin
        query_count++;
        if (!table_built || l > r || r >= stored_count) begin
          ans.status = STAT_BAD;
        end else begin
          lvl = 0;
          while (((r - l + 1) >> (lvl + 1)) != 0) lvl++;
          if (lvl >= TBL_LEVELS) begin
            ans.status = STAT_BAD;
          end else begin
            // Overlap the window from left with the window ending at right
            start2 = r + 1 - (1 << lvl);
            idx = smaller_of(index_tbl[lvl][l], index_tbl[lvl][start2]);
            ans.min_index = idx;
            ans.min_value = value_mem[idx];
            answered_count++;
          end
        end
      end
      default: ans.status = STAT_BAD;
    endcase
    ans.element_total = TOTAL_W'(stored_count);
    return ans;
  endfunction

  // Mostly no gap, some short, a few long
  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Extremes and small values that force ties
  function automatic logic [VALUE_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    if (roll < 6) return VALUE_W'($urandom_range(0, 3));
    return VALUE_W'($urandom_range(0, 65535));
  endfunction

  // Offer one transaction and record its answer once accepted
  task automatic issue_request(input logic [MODE_W-1:0] mode,
                               input logic [VALUE_W-1:0] value,
                               input logic [POS_W-1:0] left,
                               input logic [POS_W-1:0] right);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_mode  = mode;
    in_value = value;
    in_left  = left;
    in_right = right;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    min_answer_q = {min_answer_q, compute_min_answer(mode, value, left, right)};
    sent_count++;
  endtask

  // Drop valid and wait until every answer has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (min_answer_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic issue_load();
    issue_request(MODE_LOAD, pick_value(), POS_W'($urandom_range(0, 1023)),
                  POS_W'($urandom_range(0, 1023)));
  endtask

  // Mostly well-formed ranges, some noise and boundary cases
  task automatic issue_random_query();
    int roll;
    int l;
    int r;
    roll = $urandom_range(0, 99);
    if (stored_count == 0 || roll < 12) begin
      l = $urandom_range(0, 1023);
      r = $urandom_range(0, 1023);
    end else if (roll < 16 && stored_count < STORE_DEPTH) begin
      l = $urandom_range(0, stored_count - 1);
      r = stored_count;
    end else if (roll < 40) begin
      l = $urandom_range(0, stored_count - 1);
      r = l + $urandom_range(0, 3);
      if (r > stored_count - 1) r = stored_count - 1;
    end else if (roll < 48) begin
      l = 0;
      r = stored_count - 1;
    end else begin
      l = $urandom_range(0, stored_count - 1);
      r = $urandom_range(l, stored_count - 1);
    end
    issue_request(MODE_QUERY, pick_value(), POS_W'(l), POS_W'(r));
  endtask

  // Append values, build, then query the new table, with an occasional early query, second build or unused mode
  task automatic run_round(input int max_loads);
    int n;
    n = $urandom_range(1, max_loads);
    repeat (n) issue_load();
    if ($urandom_range(0, 7) == 0) issue_random_query();
    issue_request(MODE_BUILD, pick_value(), '0, '0);
    if ($urandom_range(0, 5) == 0) issue_request(MODE_BUILD, pick_value(), '1, '1);
    n = $urandom_range(8, 24);
    repeat (n) begin
      if ($urandom_range(0, 19) == 0)
        issue_request(MODE_UNUSED, pick_value(), POS_W'($urandom_range(0, 1023)),
                      POS_W'($urandom_range(0, 1023)));
      else
        issue_random_query();
    end
  endtask

  // Everything on an empty store is rejected
  task automatic test_empty_store();
    issue_request(MODE_QUERY, '0, '0, '0);
    issue_request(MODE_BUILD, '0, '0, '0);
    issue_request(MODE_UNUSED, '1, '1, '1);
  endtask

  // Extreme values, ties, overlapping windows and rejected ranges
  task automatic test_directed_small();
    logic [VALUE_W-1:0] vals [8];
    vals = '{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0001, 16'hAAAA, 16'h5555, 16'h0000};
    foreach (vals[k]) issue_request(MODE_LOAD, vals[k], '1, '0);
    issue_request(MODE_QUERY, '0, 10'd0, 10'd7);
    issue_request(MODE_BUILD, '0, '0, '0);
    issue_request(MODE_QUERY, '0, 10'd0, 10'd0);
    issue_request(MODE_QUERY, '0, 10'd0, 10'd7);
    issue_request(MODE_QUERY, '0, 10'd1, 10'd2);
    issue_request(MODE_QUERY, '0, 10'd2, 10'd6);
    issue_request(MODE_QUERY, '0, 10'd7, 10'd7);
    issue_request(MODE_QUERY, '0, 10'd0, 10'd8);
    issue_request(MODE_QUERY, '0, 10'd5, 10'd4);
    issue_request(MODE_QUERY, '0, 10'd1023, 10'd1023);
    // A load clears the built mark until the next build
    issue_request(MODE_LOAD, 16'h0000, '0, '0);
    issue_request(MODE_QUERY, '0, 10'd0, 10'd8);
    issue_request(MODE_BUILD, '0, '0, '0);
    issue_request(MODE_QUERY, '0, 10'd0, 10'd8);
    issue_request(MODE_UNUSED, '1, '1, '1);
  endtask

  // Hold the receiver off while queries keep coming, then pause until empty
  task automatic test_backpressure();
    drain_results();
    long_hold_req = 1'b1;
    repeat (16) issue_random_query();
    drain_results();
  endtask

  task automatic test_random_rounds();
    int start;
    start = sent_count;
    while (sent_count - start < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      run_round(12);
    end
    calm = 1'b0;
  endtask

  // Back-to-back transactions with no gaps on either side
  task automatic test_calm_stream();
    drain_results();
    calm = 1'b1;
    repeat (3) run_round(4);
    calm = 1'b0;
  endtask

  // Fill the store, query the full table, then load into a full store
  task automatic test_store_full();
    while (stored_count < STORE_DEPTH) issue_load();
    issue_request(MODE_QUERY, '0, 10'd0, 10'd1023);
    issue_request(MODE_BUILD, '0, '0, '0);
    issue_request(MODE_QUERY, '0, 10'd0, 10'd1023);
    repeat (80) issue_random_query();
    issue_request(MODE_LOAD, '1, '0, '0);
    issue_request(MODE_LOAD, '0, '1, '1);
    // A rejected load keeps the table usable
    issue_request(MODE_QUERY, '0, 10'd0, 10'd1023);
    issue_request(MODE_QUERY, '0, 10'd512, 10'd1023);
    issue_request(MODE_UNUSED, '0, '0, '0);
  endtask

  // Receiver: random stalls, plus one long hold on request
  initial begin : receiver
    int hold_cycles;
    int gap;
    out_ready = 1'b0;
    hold_cycles = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_cycles = LONG_HOLD;
      end
      if (hold_cycles > 0) begin
        out_ready = 1'b0;
        hold_cycles--;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready = 1'b0;
          hold_cycles = gap - 1;
        end else begin
          out_ready = 1'b1;
        end
      end
    end
  end

  // Compare each result transaction with the oldest answer
  always @(posedge clk) begin : check_results
    min_answer_t want;
    if (rst_n && out_valid && out_ready) begin
      if (min_answer_q.size() == 0) begin
        $error("result with no transaction pending: index %0d value %0d status %0d",
               out_min_index, out_min_value, out_status);
        fail_count++;
      end else begin
        want = min_answer_q.pop_front();
        if (out_min_index !== want.min_index) begin
          $error("min_index expected %0d got %0d", want.min_index, out_min_index);
          fail_count++;
        end
        if (out_min_value !== want.min_value) begin
          $error("min_value expected %0d got %0d", want.min_value, out_min_value);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $error("status expected %0d got %0d", want.status, out_status);
          fail_count++;
        end
        if (out_element_total !== want.element_total) begin
          $error("element_total expected %0d got %0d", want.element_total,
                 out_element_total);
          fail_count++;
        end
      end
    end
  end

  initial begin : run
    in_valid = 1'b0;
    in_mode  = MODE_LOAD;
    in_value = '0;
    in_left  = '0;
    in_right = '0;
    rst_n    = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_store();
    test_directed_small();
    test_backpressure();
    test_random_rounds();
    test_calm_stream();
    test_store_full();

    // Let any late result show up before judging
    drain_results();
    repeat (40) @(posedge clk);

    $display("Ran %0d transactions: %0d loads (%0d into a full store), %0d builds,",
             sent_count, load_count, full_loads, build_count);
    $display("%0d range queries with %0d answered; store grew to %0d elements.",
             query_count, answered_count, stored_count);
    if (fail_count == 0)
      $display("[sparse_table_range_min_index] OK");
    else
      $display("[sparse_table_range_min_index] ERROR");
    $finish;
  end

endmodule
